FILE: rtl/core/signed_angle_between_vectors_assert.svh
// ---------------------------------------------------------------------------
// signed_angle_between_vectors_assert.svh
// assertion macros for the signed angle block, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef SIGNED_ANGLE_BETWEEN_VECTORS_ASSERT_SVH
`define SIGNED_ANGLE_BETWEEN_VECTORS_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on the block clock
`define SABV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("signed angle assertion failed");

// next-cycle implication
`define SABV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("signed angle assertion failed");

`else

`define SABV_ASSERT_NOW(label, ante, cons)
`define SABV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/sabv_pkg.sv
// ---------------------------------------------------------------------------
// sabv_pkg
// shared widths, constants, cordic angle table and helpers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sabv_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 24;
   localparam int MAX_STEPS            = 32;

   localparam int IN_W    = 32;             // q16.16 coordinates
   localparam int DIFF_W  = IN_W + 1;       // difference vector component
   localparam int PRE_SCALE = 24;
   localparam int XY_W    = 60;             // cordic x / y datapath
   localparam int Z_W     = 32;             // cordic angle accumulator
   localparam int ANG_W   = 31;             // q3.28 result
   localparam int ATAN_W  = 28;
   localparam int LIM_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-3:0] CSR_NEAR_ZERO_LIMIT = 1'b0;

   localparam logic signed [Z_W-1:0]   Z_HALF_PI   = 32'sd421657428;
   localparam logic signed [DIFF_W:0]  WRAP_PI     = 34'sd843314857;
   localparam logic signed [DIFF_W:0]  WRAP_TWO_PI = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] ANGLE_PI    = 31'sd843314857;

   typedef logic [ATAN_W-1:0] atan_table_type [0:MAX_STEPS-1];

   // atan(2^-i) in q3.28, rounded to nearest
   localparam atan_table_type ATAN_TABLE = '{
      28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290,
      28'd16755422,  28'd8385879,   28'd4193963,  28'd2097109,
      28'd1048571,   28'd524287,    28'd262144,   28'd131072,
      28'd65536,     28'd32768,     28'd16384,    28'd8192,
      28'd4096,      28'd2048,      28'd1024,     28'd512,
      28'd256,       28'd128,       28'd64,       28'd32,
      28'd16,        28'd8,         28'd4,        28'd2,
      28'd1,         28'd0,         28'd0,        28'd0
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_vec_type;

   // scale up and turn left-half-plane vectors into the right half plane
   function automatic cordic_vec_type prerotate(input logic signed [DIFF_W-1:0] dx,
                                                input logic signed [DIFF_W-1:0] dy);
      cordic_vec_type r;
      logic signed [XY_W-1:0] sx;
      logic signed [XY_W-1:0] sy;
      sx = {{(XY_W-DIFF_W-PRE_SCALE){dx[DIFF_W-1]}}, dx, {PRE_SCALE{1'b0}}};
      sy = {{(XY_W-DIFF_W-PRE_SCALE){dy[DIFF_W-1]}}, dy, {PRE_SCALE{1'b0}}};
      if (sx < 0) begin
         if (sy >= 0) begin
            r.x = sy;
            r.y = -sx;
            r.z = Z_HALF_PI;
         end else begin
            r.x = -sy;
            r.y = sx;
            r.z = -Z_HALF_PI;
         end
      end else begin
         r.x = sx;
         r.y = sy;
         r.z = '0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sabv_cordic.sv
// ---------------------------------------------------------------------------
// sabv_cordic
// pipelined cordic vectoring lane, one micro-rotation per register stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sabv_cordic import sabv_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  cordic_vec_type        vec_in,
   output logic signed [Z_W-1:0] z_out
);

   logic signed [XY_W-1:0] x_ff [0:STEPS-2];
   logic signed [XY_W-1:0] y_ff [0:STEPS-2];
   logic signed [Z_W-1:0]  z_ff [0:STEPS-1];

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic signed [XY_W-1:0] y_cur;
         logic signed [Z_W-1:0]  z_cur;
         logic signed [Z_W-1:0]  z_step;

         if (i == 0) begin : g_first
            assign y_cur = vec_in.y;
            assign z_cur = vec_in.z;
         end else begin : g_rest
            assign y_cur = y_ff[i-1];
            assign z_cur = z_ff[i-1];
         end

         assign z_step = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[i]});

         // x and y only needed up to the last decision
         if (i < STEPS - 1) begin : g_xy
            logic signed [XY_W-1:0] x_cur;
            logic signed [XY_W-1:0] x_sh;
            logic signed [XY_W-1:0] y_sh;

            if (i == 0) begin : g_xfirst
               assign x_cur = vec_in.x;
            end else begin : g_xrest
               assign x_cur = x_ff[i-1];
            end

            // arithmetic shift rounds toward minus infinity
            assign x_sh = x_cur >>> i;
            assign y_sh = y_cur >>> i;

            always_ff @(posedge clock) begin
               if (y_cur >= 0) begin
                  x_ff[i] <= x_cur + y_sh;
                  y_ff[i] <= y_cur - x_sh;
               end else begin
                  x_ff[i] <= x_cur - y_sh;
                  y_ff[i] <= y_cur + x_sh;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (y_cur >= 0) begin
               z_ff[i] <= z_cur + z_step;
            end else begin
               z_ff[i] <= z_cur - z_step;
            end
         end
      end
   endgenerate

   assign z_out = z_ff[STEPS-1];

endmodule

FILE: rtl/core/signed_angle_between_vectors.sv
// ---------------------------------------------------------------------------
// signed_angle_between_vectors
// signed angle from a first to a second 2d vector sharing one origin, q3.28
// registers to the strobe: difference, pre-rotation, cordic, angle difference, result
// throughput: one request every cycle, busy is never raised
// the depth is set by the cordic lanes, one micro-rotation per stage
// reset: synchronous; clears valid bits and near_zero_limit, drops requests in flight
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_angle_between_vectors_assert.svh"

module signed_angle_between_vectors import sabv_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic signed [IN_W-1:0]   req_origin_x,
   input  logic signed [IN_W-1:0]   req_origin_y,
   input  logic signed [IN_W-1:0]   req_first_end_x,
   input  logic signed [IN_W-1:0]   req_first_end_y,
   input  logic signed [IN_W-1:0]   req_second_end_x,
   input  logic signed [IN_W-1:0]   req_second_end_y,

   // result channel, one strobe per request
   output logic                     rsp_valid,
   output logic signed [ANG_W-1:0]  rsp_angle,
   output logic                     rsp_bad_input,

   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   // steps beyond the table length add nothing
   localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [LIM_W-1:0] lim_ff;
   logic             csr_hit;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_NEAR_ZERO_LIMIT);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? {{(CSR_DATA_W-LIM_W){1'b0}}, lim_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '0;
      end else if (csr_write && csr_hit) begin
         lim_ff <= pwdata[LIM_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // stage 1: difference vectors at full 33-bit precision
   // ------------------------------------------------------------------
   logic                     accept;
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;

   // the pipeline never stalls, so a request is taken whenever it is offered
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      d1x_ff <= {req_first_end_x[IN_W-1], req_first_end_x}
              - {req_origin_x[IN_W-1], req_origin_x};
      d1y_ff <= {req_first_end_y[IN_W-1], req_first_end_y}
              - {req_origin_y[IN_W-1], req_origin_y};
      d2x_ff <= {req_second_end_x[IN_W-1], req_second_end_x}
              - {req_origin_x[IN_W-1], req_origin_x};
      d2y_ff <= {req_second_end_y[IN_W-1], req_second_end_y}
              - {req_origin_y[IN_W-1], req_origin_y};
   end

   // ------------------------------------------------------------------
   // stage 2: near-zero test and quadrant pre-rotation
   // ------------------------------------------------------------------
   logic signed [DIFF_W:0] lim_pos;
   logic signed [DIFF_W:0] lim_neg;
   logic                   near1;
   logic                   near2;
   logic                   s2_valid_ff;
   logic                   s2_bad_ff;
   cordic_vec_type         vec1_ff;
   cordic_vec_type         vec2_ff;

   assign lim_pos = $signed({{(DIFF_W+1-LIM_W){1'b0}}, lim_ff});
   assign lim_neg = -lim_pos;

   // |d| <= limit written as two signed compares, no abs needed
   assign near1 = ($signed({d1x_ff[DIFF_W-1], d1x_ff}) <= lim_pos)
               && ($signed({d1x_ff[DIFF_W-1], d1x_ff}) >= lim_neg)
               && ($signed({d1y_ff[DIFF_W-1], d1y_ff}) <= lim_pos)
               && ($signed({d1y_ff[DIFF_W-1], d1y_ff}) >= lim_neg);
   assign near2 = ($signed({d2x_ff[DIFF_W-1], d2x_ff}) <= lim_pos)
               && ($signed({d2x_ff[DIFF_W-1], d2x_ff}) >= lim_neg)
               && ($signed({d2y_ff[DIFF_W-1], d2y_ff}) <= lim_pos)
               && ($signed({d2y_ff[DIFF_W-1], d2y_ff}) >= lim_neg);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bad_ff <= near1 || near2;
      vec1_ff   <= prerotate(d1x_ff, d1y_ff);
      vec2_ff   <= prerotate(d2x_ff, d2y_ff);
   end

   // ------------------------------------------------------------------
   // cordic stages: two lanes side by side, valid and bad flag alongside
   // ------------------------------------------------------------------
   logic signed [Z_W-1:0] z1;
   logic signed [Z_W-1:0] z2;
   logic                  valid_pipe_ff [0:NSTEPS-1];
   logic                  bad_pipe_ff   [0:NSTEPS-1];

   sabv_cordic #(.STEPS(NSTEPS)) u_cordic_first (
      .clock  (clock),
      .vec_in (vec1_ff),
      .z_out  (z1)
   );

   sabv_cordic #(.STEPS(NSTEPS)) u_cordic_second (
      .clock  (clock),
      .vec_in (vec2_ff),
      .z_out  (z2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTEPS; k++) begin
            valid_pipe_ff[k] <= 1'b0;
         end
      end else begin
         valid_pipe_ff[0] <= s2_valid_ff;
         for (int k = 1; k < NSTEPS; k++) begin
            valid_pipe_ff[k] <= valid_pipe_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      bad_pipe_ff[0] <= s2_bad_ff;
      for (int k = 1; k < NSTEPS; k++) begin
         bad_pipe_ff[k] <= bad_pipe_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // difference of the two angles
   // ------------------------------------------------------------------
   logic                     dif_valid_ff;
   logic                     dif_bad_ff;
   logic signed [DIFF_W-1:0] dif_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_valid_ff <= 1'b0;
      end else begin
         dif_valid_ff <= valid_pipe_ff[NSTEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      dif_bad_ff <= bad_pipe_ff[NSTEPS-1];
      dif_ff     <= {z2[Z_W-1], z2} - {z1[Z_W-1], z1};
   end

   // ------------------------------------------------------------------
   // wrap into [-pi, pi], clamp, and the result register
   // ------------------------------------------------------------------
   logic signed [DIFF_W:0] dif_ext;
   logic signed [DIFF_W:0] wrapped;
   logic signed [DIFF_W:0] clamped;
   logic                   out_valid_ff;
   logic                   out_bad_ff;
   logic signed [ANG_W-1:0] out_angle_ff;

   assign dif_ext = {dif_ff[DIFF_W-1], dif_ff};

   always_comb begin
      if (dif_ext > WRAP_PI) begin
         wrapped = dif_ext - WRAP_TWO_PI;
      end else if (dif_ext < -WRAP_PI) begin
         wrapped = dif_ext + WRAP_TWO_PI;
      end else begin
         wrapped = dif_ext;
      end
      if (wrapped > WRAP_PI) begin
         clamped = WRAP_PI;
      end else if (wrapped < -WRAP_PI) begin
         clamped = -WRAP_PI;
      end else begin
         clamped = wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dif_valid_ff;
      end
   end

   // a near-zero vector forces the angle to zero
   always_ff @(posedge clock) begin
      out_bad_ff   <= dif_bad_ff;
      out_angle_ff <= dif_bad_ff ? '0 : clamped[ANG_W-1:0];
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_angle     = out_angle_ff;
   assign rsp_bad_input = out_bad_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `SABV_ASSERT_NOW(a_bad_gives_zero, rsp_valid && rsp_bad_input, rsp_angle == '0)
   `SABV_ASSERT_NOW(a_angle_in_range, rsp_valid, (rsp_angle <= ANGLE_PI) && (rsp_angle >= -ANGLE_PI))
   `SABV_ASSERT_NEXT(a_accept_enters, start && !busy, s1_valid_ff)
   `SABV_ASSERT_NEXT(a_diff_to_out, dif_valid_ff, out_valid_ff)

endmodule
